// ===== hw/rtl/gx_tiled_texture_decoder_macros.svh =====
// assertion macros shared by the decoder checks
`ifndef GX_TILED_TEXTURE_DECODER_MACROS_SVH
`define GX_TILED_TEXTURE_DECODER_MACROS_SVH

// implication in the same cycle, muted while reset is low
`define GXTTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gxttd check failed");

// implication in the next cycle, muted while reset is low
`define GXTTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gxttd check failed");

// implication in the next cycle, always active
`define GXTTD_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gxttd check failed");

`endif

// ===== hw/rtl/gxttd_pkg.sv =====
// types, codes and pixel helper functions of the tiled texture decoder
package gxttd_pkg;

    typedef enum logic [3:0] {
        FMT_I4, FMT_I8, FMT_IA4, FMT_IA8, FMT_C4,
        FMT_C8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8, FMT_CMPR
    } t_texel_format;

    typedef enum logic [1:0] {
        OP_PAL_WRITE = 2'd0,
        OP_UNIT      = 2'd1,
        OP_RESTART   = 2'd2
    } t_opcode;

    localparam logic [1:0] PAL_IA8    = 2'd0;
    localparam logic [1:0] PAL_RGB565 = 2'd1;
    localparam logic [1:0] PAL_RGB5A3 = 2'd2;

    localparam logic [2:0] REG_TEXEL_FORMAT   = 3'd0;
    localparam logic [2:0] REG_PALETTE_FORMAT = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_MIP_LEVELS     = 3'd4;

    // converted pixels of one source word
    typedef struct packed {
        logic [63:0] val0;
        logic [63:0] val1;
        logic        two;
    } t_conv;

    function automatic logic [7:0] ext3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

    function automatic logic [7:0] ext4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] ext5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [31:0] rgb5a3_argb(input logic [15:0] p);
        logic [31:0] r;
        if (p[15]) begin
            r = {8'hFF, ext5(p[14:10]), ext5(p[9:5]), ext5(p[4:0])};
        end else begin
            r = {ext3(p[14:12]), ext4(p[11:8]), ext4(p[7:4]), ext4(p[3:0])};
        end
        return r;
    endfunction

    function automatic logic [7:0] reverse_pairs(input logic [7:0] b);
        return {b[1:0], b[3:2], b[5:4], b[7:6]};
    endfunction

    function automatic logic [3:0] blk_w(input logic [3:0] fmt);
        logic [3:0] r;
        unique case (fmt)
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8: r = 4'd4;
            FMT_CMPR: r = 4'd2;
            default:  r = 4'd8;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] blk_h(input logic [3:0] fmt);
        logic [3:0] r;
        unique case (fmt)
            FMT_I4, FMT_C4: r = 4'd8;
            FMT_CMPR:       r = 4'd2;
            default:        r = 4'd4;
        endcase
        return r;
    endfunction

    // log2 of the pixel byte stride
    function automatic logic [1:0] stride_shift(input logic [3:0] fmt, input logic [1:0] pal);
        logic [1:0] r;
        unique case (fmt)
            FMT_C4, FMT_C8: r = (pal == PAL_RGB5A3) ? 2'd2 : 2'd1;
            FMT_IA4, FMT_IA8, FMT_RGB565: r = 2'd1;
            FMT_RGB5A3, FMT_RGBA8: r = 2'd2;
            FMT_CMPR: r = 2'd3;
            default:  r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/gxttd_if.sv =====
// handshake channels of the tiled texture decoder

interface gxttd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  palette_slot;
    logic [63:0] source_value;
    modport source (output valid, opcode, palette_slot, source_value, input ready);
    modport sink (input valid, opcode, palette_slot, source_value, output ready);
endinterface

interface gxttd_out_if #(parameter int OFFSET_BITS = 23);
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] dest_offset;
    logic [63:0]            pixel_value;
    logic [3:0]             pixel_bytes;
    logic                   run_last;
    logic                   image_done;
    modport source (output valid, dest_offset, pixel_value, pixel_bytes, run_last, image_done,
                    input ready);
    modport sink (input valid, dest_offset, pixel_value, pixel_bytes, run_last, image_done,
                  output ready);
endinterface

interface gxttd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gxttd_ram.sv =====
// generic ram, one write port, two registered read ports
module gxttd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ===== hw/rtl/gxttd_pixel_conv.sv =====
// converts one source word into one or two pixel values
module gxttd_pixel_conv
    import gxttd_pkg::*;
(
    input  logic [3:0]  i_texel_format,
    input  logic [1:0]  i_palette_format,
    input  logic [63:0] i_source,
    input  logic [15:0] i_pal_a,
    input  logic [15:0] i_pal_b,
    input  logic        i_pal_a_zero,
    input  logic [15:0] i_ar_word,
    output t_conv       o_conv
);
    logic [7:0]  b8;
    logic [15:0] h16;
    logic [15:0] ent_a;

    function automatic logic [63:0] pal_value(input logic [15:0] e, input logic [1:0] pf);
        return (pf == PAL_RGB5A3) ? 64'(rgb5a3_argb(e)) : 64'(e);
    endfunction

    assign b8    = i_source[7:0];
    assign h16   = i_source[15:0];
    assign ent_a = i_pal_a_zero ? 16'd0 : i_pal_a;

    always_comb begin
        o_conv = '0;
        unique case (i_texel_format)
            FMT_I4: begin
                o_conv.val0 = 64'(ext4(b8[7:4]));
                o_conv.val1 = 64'(ext4(b8[3:0]));
                o_conv.two  = 1'b1;
            end
            FMT_I8:  o_conv.val0 = 64'(b8);
            FMT_IA4: o_conv.val0 = 64'({ext4(b8[3:0]), ext4(b8[7:4])});
            FMT_IA8, FMT_RGB565: o_conv.val0 = 64'(h16);
            FMT_C4: begin
                o_conv.val0 = pal_value(ent_a, i_palette_format);
                o_conv.val1 = pal_value(i_pal_b, i_palette_format);
                o_conv.two  = 1'b1;
            end
            FMT_C8:     o_conv.val0 = pal_value(ent_a, i_palette_format);
            FMT_RGB5A3: o_conv.val0 = 64'(rgb5a3_argb(h16));
            FMT_RGBA8:  o_conv.val0 = 64'({i_ar_word, h16});
            default: begin
                // subblock: colours pass, index bytes get their pairs reversed
                o_conv.val0 = {i_source[63:32], reverse_pairs(i_source[31:24]),
                               reverse_pairs(i_source[23:16]), reverse_pairs(i_source[15:8]),
                               reverse_pairs(i_source[7:0])};
            end
        endcase
    end
endmodule

// ===== hw/rtl/gx_tiled_texture_decoder.sv =====
// tiled texture decoder: input word -> input register -> result output register
// throughput: one input word per cycle while results are taken; an I4 or C4 word fills
// the single result register and its one pending slot; the next word waits for the slot
// the palette ram read is issued as the word is taken and lands with the input register
// synchronous active-low reset restores default registers (8x8 I4, one level)
// and starts a traversal restart, which holds the input register while it is pending
module gx_tiled_texture_decoder
    import gxttd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_DIMENSION   = 1024,
    parameter int OFFSET_BITS     = 23
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gxttd_in_if.sink      i_in,
    gxttd_cfg_if.sink     i_cfg,
    gxttd_out_if.source   o_out
);
    localparam int AW    = $clog2(PALETTE_ENTRIES);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int LB_W  = 2 * DIM_W + 3;
    localparam int SUM_W = OFFSET_BITS + 2 * DIM_W + 6;
    localparam logic [SUM_W-1:0] OFF_MAX = SUM_W'((64'd1 << OFFSET_BITS) - 64'd1);

    // configuration registers
    logic [3:0]  r_texel_format;
    logic [1:0]  r_palette_format;
    logic [10:0] r_image_width;
    logic [10:0] r_image_height;
    logic [3:0]  r_mip_levels;
    logic        r_restart_pend;

    // input register
    logic        r_in_v;
    logic [1:0]  r_in_op;
    logic [63:0] r_in_src;

    // traversal state
    logic [3:0]             r_level_index, n_level_index;
    logic [DIM_W-1:0]       r_level_w, n_level_w;
    logic [DIM_W-1:0]       r_level_h, n_level_h;
    logic [DIM_W-1:0]       r_tile_x, n_tile_x;
    logic [DIM_W-1:0]       r_tile_y, n_tile_y;
    logic [3:0]             r_inner_x, n_inner_x;
    logic [3:0]             r_inner_y, n_inner_y;
    logic                   r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_level_base, n_level_base;
    logic [LB_W-1:0]        r_level_bytes;
    logic [15:0]            r_ar_buf [16];

    // result words: one on the port, one waiting behind it
    logic                   r_out_v, r_sec_v;
    logic [OFFSET_BITS-1:0] r_out_off, r_sec_off;
    logic [63:0]            r_out_val, r_sec_val;
    logic [3:0]             r_out_bytes, r_sec_bytes;
    logic                   r_out_last, r_out_done, r_sec_done;

    logic        in_acc, out_acc, proc_fire, proc_can;
    logic        unit_ok, ar_phase, emit, done, ar_we;
    logic [15:0] pal_a, pal_b;
    logic        pal_a_zero;
    t_conv       conv;
    logic [1:0]  sh;
    logic [3:0]  bw, bh;

    logic [DIM_W-1:0] rs_w0, rs_h0, rs_w, rs_h;
    logic [3:0]       rs_idx;

    logic [DIM_W:0]         px_x, px_y;
    logic [SUM_W-1:0]       lin, off0, off1, base_sum;
    logic [OFFSET_BITS-1:0] sat0, sat1;
    logic [DIM_W:0]         sum_tx, sum_ty;
    logic [4:0]             sum_ix;
    logic [DIM_W-1:0]       half_w, half_h;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = r_out_v & o_out.ready;
    assign proc_can  = !r_restart_pend && !r_sec_v && (!r_out_v || o_out.ready);
    assign proc_fire = r_in_v && proc_can;
    assign i_in.ready  = !r_in_v || proc_fire;
    assign i_cfg.ready = 1'b1;

    // configuration writes, every write to a known register restarts the traversal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_texel_format   <= FMT_I4;
            r_palette_format <= PAL_IA8;
            r_image_width    <= 11'd8;
            r_image_height   <= 11'd8;
            r_mip_levels     <= 4'd1;
            r_restart_pend   <= 1'b1;
        end else begin
            r_restart_pend <= 1'b0;
            if (i_cfg.valid) begin
                r_restart_pend <= 1'b1;
                unique case (i_cfg.index)
                    REG_TEXEL_FORMAT:   r_texel_format   <= i_cfg.data[3:0];
                    REG_PALETTE_FORMAT: r_palette_format <= i_cfg.data[1:0];
                    REG_IMAGE_WIDTH:    r_image_width    <= i_cfg.data;
                    REG_IMAGE_HEIGHT:   r_image_height   <= i_cfg.data;
                    REG_MIP_LEVELS:     r_mip_levels     <= i_cfg.data[3:0];
                    default:            r_restart_pend   <= 1'b0;
                endcase
            end
        end
    end

    // palette store, written and read as the input word is taken
    gxttd_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_palette (
        .i_clk     (i_clk),
        .i_we      (in_acc && i_in.opcode == OP_PAL_WRITE
                    && 9'(i_in.palette_slot) < 9'(PALETTE_ENTRIES)),
        .i_waddr   (i_in.palette_slot[AW-1:0]),
        .i_wdata   (i_in.source_value[15:0]),
        .i_re      (in_acc),
        .i_raddr_a ((r_texel_format == FMT_C4) ? AW'(i_in.source_value[7:4])
                                               : i_in.source_value[AW-1:0]),
        .i_raddr_b (AW'(i_in.source_value[3:0])),
        .o_rdata_a (pal_a),
        .o_rdata_b (pal_b)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_acc) begin
            r_in_v <= 1'b1;
        end else if (proc_fire) begin
            r_in_v <= 1'b0;
        end
        if (in_acc) begin
            r_in_op  <= i_in.opcode;
            r_in_src <= i_in.source_value;
        end
    end

    // C8 slots beyond the store read as zero
    assign pal_a_zero = (r_texel_format == FMT_C8)
                        && (9'(r_in_src[7:0]) >= 9'(PALETTE_ENTRIES));

    gxttd_pixel_conv u_conv (
        .i_texel_format   (r_texel_format),
        .i_palette_format (r_palette_format),
        .i_source         (r_in_src),
        .i_pal_a          (pal_a),
        .i_pal_b          (pal_b),
        .i_pal_a_zero     (pal_a_zero),
        .i_ar_word        (r_ar_buf[{r_inner_y[1:0], r_inner_x[1:0]}]),
        .o_conv           (conv)
    );

    assign sh = stride_shift(r_texel_format, r_palette_format);
    assign bw = blk_w(r_texel_format);
    assign bh = blk_h(r_texel_format);

    // restart values: clamp, quarter for cmpr, skip an empty base level
    always_comb begin
        rs_w0 = (13'(r_image_width) > 13'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                          : DIM_W'(r_image_width);
        rs_h0 = (13'(r_image_height) > 13'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                           : DIM_W'(r_image_height);
        if (r_texel_format == FMT_CMPR) begin
            rs_w0 = rs_w0 >> 2;
            rs_h0 = rs_h0 >> 2;
        end
        if (r_texel_format <= FMT_CMPR && (rs_w0 == '0 || rs_h0 == '0)
            && r_mip_levels != 4'd0) begin
            // skipped level halves both sides, no smaller than one block
            rs_idx = 4'd1;
            rs_w   = ((rs_w0 >> 1) < DIM_W'(bw)) ? DIM_W'(bw) : (rs_w0 >> 1);
            rs_h   = ((rs_h0 >> 1) < DIM_W'(bh)) ? DIM_W'(bh) : (rs_h0 >> 1);
        end else begin
            rs_idx = 4'd0;
            rs_w   = rs_w0;
            rs_h   = rs_h0;
        end
    end

    // byte size of the current level, ready long before the level ends
    always_ff @(posedge i_clk) begin
        r_level_bytes <= (LB_W'(r_level_w) * LB_W'(r_level_h)) << sh;
    end

    // destination offsets of both pixels
    assign px_x     = (DIM_W + 1)'(r_tile_x) + (DIM_W + 1)'(r_inner_x);
    assign px_y     = (DIM_W + 1)'(r_tile_y) + (DIM_W + 1)'(r_inner_y);
    assign lin      = SUM_W'(px_y) * SUM_W'(r_level_w) + SUM_W'(px_x);
    assign off0     = SUM_W'(r_level_base) + (lin << sh);
    assign off1     = SUM_W'(r_level_base) + ((lin + SUM_W'(1)) << sh);
    assign sat0     = (off0 > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0] : off0[OFFSET_BITS-1:0];
    assign sat1     = (off1 > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0] : off1[OFFSET_BITS-1:0];
    assign base_sum = SUM_W'(r_level_base) + SUM_W'(r_level_bytes);

    assign unit_ok  = r_in_op == OP_UNIT && r_texel_format <= FMT_CMPR
                      && r_level_index < r_mip_levels;
    assign ar_phase = r_texel_format == FMT_RGBA8 && !r_phase;
    assign emit     = unit_ok && !ar_phase;

    assign sum_ix = 5'(r_inner_x) + (conv.two ? 5'd2 : 5'd1);
    assign sum_tx = (DIM_W + 1)'(r_tile_x) + (DIM_W + 1)'(bw);
    assign sum_ty = (DIM_W + 1)'(r_tile_y) + (DIM_W + 1)'(bh);
    assign half_w = r_level_w >> 1;
    assign half_h = r_level_h >> 1;

    // traversal counters
    always_comb begin
        n_level_index = r_level_index;
        n_level_w     = r_level_w;
        n_level_h     = r_level_h;
        n_tile_x      = r_tile_x;
        n_tile_y      = r_tile_y;
        n_inner_x     = r_inner_x;
        n_inner_y     = r_inner_y;
        n_phase       = r_phase;
        n_level_base  = r_level_base;
        done          = 1'b0;
        ar_we         = 1'b0;
        priority if (r_restart_pend || (proc_fire && r_in_op == OP_RESTART)) begin
            n_level_index = rs_idx;
            n_level_w     = rs_w;
            n_level_h     = rs_h;
            n_tile_x      = '0;
            n_tile_y      = '0;
            n_inner_x     = '0;
            n_inner_y     = '0;
            n_phase       = 1'b0;
            n_level_base  = '0;
        end else if (proc_fire && unit_ok && ar_phase) begin
            // alpha-red half of an rgba8 tile, buffered only
            ar_we = 1'b1;
            n_inner_x = r_inner_x + 4'd1;
            if (r_inner_x + 4'd1 >= 4'd4) begin
                n_inner_x = '0;
                n_inner_y = r_inner_y + 4'd1;
                if (r_inner_y + 4'd1 >= 4'd4) begin
                    n_inner_y = '0;
                    n_phase   = 1'b1;
                end
            end
        end else if (proc_fire && emit) begin
            n_inner_x = sum_ix[3:0];
            if (sum_ix >= 5'(bw)) begin
                n_inner_x = '0;
                n_inner_y = r_inner_y + 4'd1;
                if (r_inner_y + 4'd1 >= bh) begin
                    n_inner_y = '0;
                    n_phase   = 1'b0;
                    n_tile_x  = sum_tx[DIM_W-1:0];
                    if (sum_tx >= (DIM_W + 1)'(r_level_w)) begin
                        n_tile_x = '0;
                        n_tile_y = sum_ty[DIM_W-1:0];
                        if (sum_ty >= (DIM_W + 1)'(r_level_h)) begin
                            // level complete, step to the next mip level
                            n_tile_y     = '0;
                            n_level_base = (base_sum > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0]
                                                                : base_sum[OFFSET_BITS-1:0];
                            n_level_w    = (half_w < DIM_W'(bw)) ? DIM_W'(bw) : half_w;
                            n_level_h    = (half_h < DIM_W'(bh)) ? DIM_W'(bh) : half_h;
                            if (r_level_index != 4'd15) begin
                                n_level_index = r_level_index + 4'd1;
                            end
                            done = n_level_index >= r_mip_levels;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_index <= '0;
            r_tile_x      <= '0;
            r_tile_y      <= '0;
            r_inner_x     <= '0;
            r_inner_y     <= '0;
            r_phase       <= 1'b0;
            r_level_base  <= '0;
        end else begin
            r_level_index <= n_level_index;
            r_tile_x      <= n_tile_x;
            r_tile_y      <= n_tile_y;
            r_inner_x     <= n_inner_x;
            r_inner_y     <= n_inner_y;
            r_phase       <= n_phase;
            r_level_base  <= n_level_base;
        end
        r_level_w <= n_level_w;
        r_level_h <= n_level_h;
        if (ar_we) begin
            r_ar_buf[{r_inner_y[1:0], r_inner_x[1:0]}] <= r_in_src[15:0];
        end
    end

    // result words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sec_v <= 1'b0;
        end else if (proc_fire && emit) begin
            r_out_v <= 1'b1;
            r_sec_v <= conv.two;
        end else if (out_acc) begin
            r_out_v <= r_sec_v;
            r_sec_v <= 1'b0;
        end
        if (proc_fire && emit) begin
            r_out_off   <= sat0;
            r_out_val   <= conv.val0;
            r_out_bytes <= 4'(4'd1 << sh);
            r_out_last  <= !conv.two;
            r_out_done  <= !conv.two && done;
            r_sec_off   <= sat1;
            r_sec_val   <= conv.val1;
            r_sec_bytes <= 4'(4'd1 << sh);
            r_sec_done  <= done;
        end else if (out_acc && r_sec_v) begin
            r_out_off   <= r_sec_off;
            r_out_val   <= r_sec_val;
            r_out_bytes <= r_sec_bytes;
            r_out_last  <= 1'b1;
            r_out_done  <= r_sec_done;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.dest_offset = r_out_off;
    assign o_out.pixel_value = r_out_val;
    assign o_out.pixel_bytes = r_out_bytes;
    assign o_out.run_last    = r_out_last;
    assign o_out.image_done  = r_out_done;
endmodule

// ===== hw/rtl/gxttd_checker.sv =====
// port checks of the tiled texture decoder, bound to the top level
`include "gx_tiled_texture_decoder_macros.svh"

module gxttd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_value,
    input logic [3:0]  i_out_bytes,
    input logic        i_out_last,
    input logic        i_out_done
);
    // a stalled word keeps its pixel
    `GXTTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value) && i_out_valid)
    // image end only on the last word of a run
    `GXTTD_ASSERT_NOW(a_done_last, i_clk, i_rst_n, i_out_valid && i_out_done, i_out_last)
    // pixel size is a power of two
    `GXTTD_ASSERT_NOW(a_bytes_pow2, i_clk, i_rst_n, i_out_valid, $onehot(i_out_bytes))
    // reset empties the result register
    `GXTTD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind gx_tiled_texture_decoder gxttd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.pixel_value),
    .i_out_bytes (o_out.pixel_bytes),
    .i_out_last  (o_out.run_last),
    .i_out_done  (o_out.image_done)
);
